[hw/rtl/trt_pkg.sv]
// Shared types and constants of the transaction retry tracker.
// Used by trt_ctrl, trt_dp and transaction_retry_tracker_top; no dependencies.
package trt_pkg;

	localparam int MAX_IDS = 32;
	localparam int IW      = $clog2(MAX_IDS);
	localparam int CW      = $clog2(MAX_IDS) + 1;

	localparam int FUNC_W  = 3;
	localparam int ID_W    = 5;
	localparam int KIND_W  = 3;
	localparam int RC_W    = 4;
	localparam int TMO_W   = 20;
	localparam int INIT_W  = 12;
	localparam int FACT_W  = 4;
	localparam int PROD_W  = INIT_W + FACT_W;
	localparam int ENT_W   = RC_W + TMO_W;
	localparam int CFG_IW  = 2;
	localparam int CFG_DW  = 12;

	localparam logic [FUNC_W-1:0] FUNC_ISSUE = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_RESP  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_REQ   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_FLUSH = 3'd4;

	localparam logic [KIND_W-1:0] KIND_SEND    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_RETX    = 3'd1;
	localparam logic [KIND_W-1:0] KIND_ACK     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ERR     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd4;
	localparam logic [KIND_W-1:0] KIND_RESP    = 3'd5;

	localparam logic [CFG_IW-1:0] REG_ENABLE  = 2'd0;
	localparam logic [CFG_IW-1:0] REG_MAX_RTY = 2'd1;
	localparam logic [CFG_IW-1:0] REG_INIT    = 2'd2;
	localparam logic [CFG_IW-1:0] REG_FACTOR  = 2'd3;

	localparam logic              RST_ENABLE  = 1'b1;
	localparam logic [RC_W-1:0]   RST_MAX_RTY = 4'd3;
	localparam logic [INIT_W-1:0] RST_INIT    = 12'd500;
	localparam logic [FACT_W-1:0] RST_FACTOR  = 4'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RESP,
		ST_TICK,
		ST_LAST
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IW-1:0]     id;
		logic [RC_W-1:0]   rc;
		logic [TMO_W-1:0]  tmo;
		logic              ovw;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic do_issue;     // issue accepted
		logic do_req;       // request accepted while enabled
		logic do_flush;     // flush accepted
		logic resp_rd;      // response hit accepted, read its entry
		logic resp_take;    // entry data back, complete the response
		logic walk_start;   // tick accepted
		logic walk_step;    // advance the timer walk one entry
		logic hold_last;    // move held result to output, last set
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic enabled;
		logic resp_hit;
		logic out_free;
		logic hold_valid;
		logic ev_result;
		logic walk_done;
	} dp_status_t;

endpackage

[hw/rtl/trt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module trt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/trt_ctrl.sv]
// Controller state machine of the transaction retry tracker.
// Depends on trt_pkg; drives trt_dp through ctrl_cmd_t.
module trt_ctrl import trt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [FUNC_W-1:0] func,
	input  dp_status_t        st,
	output logic              in_ready,
	output ctrl_cmd_t         cmd
);

	state_t state_q, state_d;
	logic   stall;

	// a new tick result can't enter while the held one can't leave
	assign stall = st.ev_result && st.hold_valid && !st.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (func)
						FUNC_ISSUE: state_d = ST_LAST;
						FUNC_RESP:  if (st.resp_hit) state_d = ST_RESP;
						FUNC_TICK:  state_d = ST_TICK;
						FUNC_REQ:   if (st.enabled) state_d = ST_LAST;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_RESP: state_d = ST_LAST;
			ST_TICK: begin
				if (st.walk_done) begin
					state_d = st.hold_valid ? ST_LAST : ST_IDLE;
				end
			end
			ST_LAST: if (st.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (func)
						FUNC_ISSUE: cmd.do_issue   = 1'b1;
						FUNC_RESP:  cmd.resp_rd    = st.resp_hit;
						FUNC_TICK:  cmd.walk_start = 1'b1;
						FUNC_REQ:   cmd.do_req     = st.enabled;
						FUNC_FLUSH: cmd.do_flush   = 1'b1;
						default:    cmd            = '0;
					endcase
				end
			end
			ST_RESP: cmd.resp_take = 1'b1;
			ST_TICK: cmd.walk_step = !st.walk_done && !stall;
			ST_LAST: cmd.hold_last = st.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

[hw/rtl/trt_dp.sv]
// Datapath of the transaction retry tracker: config registers, pending bits,
// entry RAM, timer walk, result hold and output registers.
// Depends on trt_pkg and trt_ram.
module trt_dp import trt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_cmd_t         cmd,
	output dp_status_t        st,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic [ID_W-1:0]   txn_id,
	input  logic              resp_success,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] kind,
	output logic [ID_W-1:0]   out_id,
	output logic [RC_W-1:0]   retry_count,
	output logic [TMO_W-1:0]  next_timeout,
	output logic              overwrote_pending,
	output logic              last
);

	// configuration
	logic              enable_q;
	logic [RC_W-1:0]   max_rty_q;
	logic [INIT_W-1:0] init_q;
	logic [FACT_W-1:0] factor_q;
	logic [PROD_W-1:0] prod_q, prod_d;

	logic [IW-1:0]      next_id_q;
	logic [MAX_IDS-1:0] pending_q;
	logic               ok_q;
	logic [IW-1:0]      rid_q;

	// walk
	logic [CW-1:0] idx_q;
	logic [IW-1:0] idx_s1;
	logic          valid_s1;
	logic          idx_more;

	// ram
	logic             ram_we, ram_re;
	logic [IW-1:0]    ram_waddr, ram_raddr;
	logic [ENT_W-1:0] ram_wdata, ram_rdata;

	// entry evaluation
	logic [RC_W-1:0]        ev_rc, rc_inc;
	logic [TMO_W-1:0]       ev_tmo;
	logic [PROD_W+RC_W-1:0] mul_full;
	logic                   ev_active, ev_dec, ev_retx, ev_result, ev_commit;
	result_t                ev_res;

	result_t hold_q;
	logic    hold_valid_q;
	result_t out_q;
	logic    out_valid_q, out_last_q, out_free;
	logic    push_mid;

	logic [TMO_W-1:0] init_tmo;
	logic [IW-1:0]    tid_idx;
	logic             tid_in_range;

	assign init_tmo     = TMO_W'(init_q);
	assign tid_idx      = IW'(txn_id);
	assign tid_in_range = 32'(txn_id) < MAX_IDS;
	assign idx_more     = idx_q < CW'(MAX_IDS);
	assign out_free     = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= RST_ENABLE;
			max_rty_q <= RST_MAX_RTY;
			init_q    <= RST_INIT;
			factor_q  <= RST_FACTOR;
			prod_q    <= PROD_W'(RST_INIT) * PROD_W'(RST_FACTOR);
		end else begin
			prod_q <= prod_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE:  enable_q  <= cfg_wdata[0];
					REG_MAX_RTY: max_rty_q <= cfg_wdata[RC_W-1:0];
					REG_INIT:    init_q    <= cfg_wdata[INIT_W-1:0];
					REG_FACTOR:  factor_q  <= cfg_wdata[FACT_W-1:0];
					default:     enable_q  <= enable_q;
				endcase
			end
		end
	end

	// base of the backoff reload, updated from the config registers
	assign prod_d = PROD_W'(init_q) * PROD_W'(factor_q);

	// ---- entry RAM: {retries_done, timer_left} ----
	always_comb begin
		ram_raddr = cmd.resp_rd ? tid_idx : idx_q[IW-1:0];
		ram_re    = cmd.resp_rd || (cmd.walk_step && idx_more);
		if (cmd.do_issue) begin
			ram_we    = 1'b1;
			ram_waddr = next_id_q;
			ram_wdata = {{RC_W{1'b0}}, init_tmo};
		end else begin
			ram_we    = ev_commit && ev_active && (ev_dec || ev_retx);
			ram_waddr = idx_s1;
			ram_wdata = ev_dec ? {ev_rc, ev_tmo - 1'b1} : {rc_inc, TMO_W'(mul_full)};
		end
	end

	trt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_IDS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---- evaluation of the entry held in the RAM read data register ----
	assign ev_rc     = ram_rdata[ENT_W-1:TMO_W];
	assign ev_tmo    = ram_rdata[TMO_W-1:0];
	assign rc_inc    = ev_rc + 1'b1;
	assign mul_full  = (PROD_W+RC_W)'(prod_q) * (PROD_W+RC_W)'(rc_inc);
	assign ev_active = valid_s1 && pending_q[idx_s1];
	assign ev_dec    = ev_tmo > TMO_W'(1);
	assign ev_retx   = ev_rc < max_rty_q;
	assign ev_result = ev_active && !ev_dec;
	assign ev_commit = cmd.walk_step;

	always_comb begin
		ev_res.id  = idx_s1;
		ev_res.ovw = 1'b0;
		if (ev_retx) begin
			ev_res.kind = KIND_RETX;
			ev_res.rc   = rc_inc;
			ev_res.tmo  = TMO_W'(mul_full);
		end else begin
			ev_res.kind = KIND_TIMEOUT;
			ev_res.rc   = ev_rc;
			ev_res.tmo  = '0;
		end
	end

	// ---- walk counter ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (cmd.walk_start) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else if (cmd.walk_step) begin
			valid_s1 <= idx_more;
			if (idx_more) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_step) begin
			idx_s1 <= idx_q[IW-1:0];
		end
		if (cmd.resp_rd) begin
			rid_q <= tid_idx;
			ok_q  <= resp_success;
		end
	end

	// ---- pending bits and id counter ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			next_id_q <= '0;
		end else begin
			if (cmd.do_flush) begin
				pending_q <= '0;
			end
			if (cmd.do_issue) begin
				pending_q[next_id_q] <= 1'b1;
				next_id_q <= (next_id_q == IW'(MAX_IDS - 1)) ? '0 : next_id_q + 1'b1;
			end
			if (cmd.resp_take) begin
				pending_q[rid_q] <= 1'b0;
			end
			if (ev_commit && ev_result && !ev_retx) begin
				pending_q[idx_s1] <= 1'b0;
			end
		end
	end

	// ---- result hold: keeps one result back until it is known to be last ----
	assign push_mid = ev_commit && ev_result && hold_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
		end else if (cmd.do_issue || cmd.do_req || cmd.resp_take ||
				(ev_commit && ev_result)) begin
			hold_valid_q <= 1'b1;
		end else if (cmd.hold_last) begin
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_issue) begin
			hold_q <= '{kind: KIND_SEND, id: next_id_q, rc: '0, tmo: init_tmo,
				ovw: pending_q[next_id_q]};
		end else if (cmd.do_req) begin
			hold_q <= '{kind: KIND_RESP, id: tid_idx, rc: '0, tmo: '0, ovw: 1'b0};
		end else if (cmd.resp_take) begin
			hold_q <= '{kind: (ok_q ? KIND_ACK : KIND_ERR), id: rid_q, rc: ev_rc,
				tmo: '0, ovw: 1'b0};
		end else if (ev_commit && ev_result) begin
			hold_q <= ev_res;
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.hold_last || push_mid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_last || push_mid) begin
			out_q      <= hold_q;
			out_last_q <= cmd.hold_last;
		end
	end

	assign out_valid         = out_valid_q;
	assign kind              = out_q.kind;
	assign out_id            = ID_W'(out_q.id);
	assign retry_count       = out_q.rc;
	assign next_timeout      = out_q.tmo;
	assign overwrote_pending = out_q.ovw;
	assign last              = out_last_q;

	assign st.enabled    = enable_q;
	assign st.resp_hit   = enable_q && tid_in_range && pending_q[tid_idx];
	assign st.out_free   = out_free;
	assign st.hold_valid = hold_valid_q;
	assign st.ev_result  = ev_result;
	assign st.walk_done  = !idx_more && !valid_s1;

endmodule

[hw/rtl/transaction_retry_tracker_top.sv]
// Top level of the transaction retry tracker.
// Depends on trt_pkg, trt_ctrl, trt_dp (which holds trt_ram).
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event item: func, txn_id,
//   resp_success. Output channel (out_valid/out_ready) carries result items;
//   'last' marks the final result of an event. Config writes (cfg_we,
//   cfg_index, cfg_wdata) take effect at once; write only while idle.
//   Issue, request and flush are acted on at accept; an issue or request result
//   passes through the hold register to the output register, a response hit
//   first reads its entry. A tick walks the entry table one entry per cycle
//   through the RAM read port, pausing while the output stalls.
//   in_ready is high only between events, so items are handled one at a time.
//   Results of a tick go through a one-deep hold register so 'last' can be
//   set on the final one; the walk pauses when a new result meets a full hold
//   and a stalled output register, and resumes when out_ready returns.
//   Reset (arst_n low) clears pending bits, the id counter, the controller
//   and output valid, and loads the config defaults (enable 1, max retries 3,
//   initial timeout 500, backoff factor 2). Entry RAM contents are not
//   cleared; entries are only used while pending.
module transaction_retry_tracker_top import trt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [FUNC_W-1:0] func,
	input  logic [ID_W-1:0]   txn_id,
	input  logic              resp_success,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [KIND_W-1:0] kind,
	output logic [ID_W-1:0]   out_id,
	output logic [RC_W-1:0]   retry_count,
	output logic [TMO_W-1:0]  next_timeout,
	output logic              overwrote_pending,
	output logic              last
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	// sequencing: decode on accept, walk on tick, drain hold at the end
	trt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	// storage, arithmetic and the output register
	trt_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.st                (st),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.txn_id            (txn_id),
		.resp_success      (resp_success),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.kind              (kind),
		.out_id            (out_id),
		.retry_count       (retry_count),
		.next_timeout      (next_timeout),
		.overwrote_pending (overwrote_pending),
		.last              (last)
	);

endmodule
